// ----- hdl/ytpq_pkg.sv -----
// Shared types and constants for the Young tableau priority queue.
// No dependencies; every other file imports this package.
`default_nettype none
package ytpq_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned MAX_ROWS = 8;
  localparam int unsigned MAX_COLS = 8;
  localparam int unsigned ROW_W    = 3;
  localparam int unsigned COL_W    = 3;
  localparam int unsigned DIM_W    = 4;
  localparam int unsigned DIAG_W   = 4;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned ST_W     = 2;

  typedef logic signed [KEY_W-1:0] key_t;

  localparam key_t EMPTY_KEY = 32'sh7FFF_FFFF;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // fill pointer: anti-diagonal and the cell on it
  typedef struct packed {
    logic [DIAG_W-1:0] fd;
    logic [ROW_W-1:0]  nr;
    logic [COL_W-1:0]  nc;
  } ptr_t;

  // direction of an exchange with a neighbour
  typedef struct packed {
    logic up;
    logic left;
    logic down;
    logic right;
  } swap_t;

  typedef struct packed {
    logic clear;
    logic start;
    logic step;
    logic sink;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ----- hdl/ytpq_in_if.sv -----
// Input channel of the priority queue: valid/ready and one operation word.
// Depends on ytpq_pkg.
`default_nettype none
interface ytpq_in_if;
  import ytpq_pkg::*;
  logic valid;
  logic ready;
  logic op;
  key_t key;
  modport source (output valid, output op, output key, input ready);
  modport sink (input valid, input op, input key, output ready);
endinterface
`default_nettype wire

// ----- hdl/ytpq_out_if.sv -----
// Result channel of the priority queue: valid/ready and one result word.
// Depends on ytpq_pkg.
`default_nettype none
interface ytpq_out_if;
  import ytpq_pkg::*;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  key_t             min_value;
  logic [CNT_W-1:0] count;
  modport source (output valid, output status, output min_value, output count, input ready);
  modport sink (input valid, input status, input min_value, input count, output ready);
endinterface
`default_nettype wire

// ----- hdl/ytpq_cell.sv -----
// One tableau cell: holds a key and the walk token, exchanges with neighbours.
// Depends on ytpq_pkg.
`default_nettype none
module ytpq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ytpq_pkg::cell_cmd_t cmd_i,
  input  logic                has_up_i,
  input  logic                has_left_i,
  input  ytpq_pkg::key_t      up_i,
  input  ytpq_pkg::key_t      left_i,
  input  ytpq_pkg::key_t      down_i,
  input  ytpq_pkg::key_t      right_i,
  input  ytpq_pkg::swap_t     nb_swap_i,
  input  logic                wr_en_i,
  input  ytpq_pkg::key_t      wr_val_i,
  input  logic                tok_set_i,
  output ytpq_pkg::key_t      val_o,
  output ytpq_pkg::swap_t     swap_o
);
  import ytpq_pkg::*;

  key_t  val_q, val_d;
  logic  tok_q, tok_d;
  logic  act, pick_up, pick_left, climb_mv, dn_ok, rt_ok;
  key_t  parent, sink_min;
  swap_t pull;

  assign act       = tok_q & cmd_i.step;
  assign pick_up   = has_up_i & (~has_left_i | (up_i > left_i));
  assign pick_left = has_left_i & ~pick_up;
  assign parent    = pick_up ? up_i : left_i;
  assign climb_mv  = (has_up_i | has_left_i) && (parent > val_q);

  // empty neighbours never take part in a sink
  assign dn_ok     = (down_i != EMPTY_KEY) && (down_i < val_q);
  assign sink_min  = dn_ok ? down_i : val_q;
  assign rt_ok     = (right_i != EMPTY_KEY) && (right_i < sink_min);

  assign swap_o.up    = act & ~cmd_i.sink & climb_mv & pick_up;
  assign swap_o.left  = act & ~cmd_i.sink & climb_mv & pick_left;
  assign swap_o.down  = act & cmd_i.sink & dn_ok & ~rt_ok;
  assign swap_o.right = act & cmd_i.sink & rt_ok;

  assign pull  = swap_o | nb_swap_i;
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    tok_d = tok_q;
    if (cmd_i.start) begin
      tok_d = tok_set_i;
      if (wr_en_i) begin
        val_d = wr_val_i;
      end
    end else if (cmd_i.step) begin
      // token follows the key that moves into this cell
      tok_d = |nb_swap_i;
      if (pull.up) begin
        val_d = up_i;
      end else if (pull.left) begin
        val_d = left_i;
      end else if (pull.down) begin
        val_d = down_i;
      end else if (pull.right) begin
        val_d = right_i;
      end
    end
    if (cmd_i.clear) begin
      val_d = EMPTY_KEY;
      tok_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= EMPTY_KEY;
      tok_q <= 1'b0;
    end else begin
      val_q <= val_d;
      tok_q <= tok_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ytpq_ptr.sv -----
// Fill pointer stepping: next free cell forward and back in anti-diagonal order.
// Depends on ytpq_pkg.
`default_nettype none
module ytpq_ptr (
  input  ytpq_pkg::ptr_t           ptr_i,
  input  logic [ytpq_pkg::DIM_W-1:0] rows_i,
  input  logic [ytpq_pkg::DIM_W-1:0] cols_i,
  output ytpq_pkg::ptr_t           adv_o,
  output ytpq_pkg::ptr_t           ret_o
);
  import ytpq_pkg::*;

  logic [DIM_W-1:0] nr4, nc4;
  logic [DIM_W-1:0] a_d, a_r, a_c;
  logic [DIM_W-1:0] r_d, r_cm1, r_r, r_c;

  assign nr4 = {1'b0, ptr_i.nr};
  assign nc4 = {1'b0, ptr_i.nc};

  always_comb begin
    a_d = ptr_i.fd + DIAG_W'(1);
    a_r = (a_d < rows_i) ? a_d : rows_i - DIM_W'(1);
    a_c = a_d - a_r;
    if (ptr_i.nr != '0 && (nc4 + DIM_W'(1)) < cols_i) begin
      adv_o.fd = ptr_i.fd;
      adv_o.nr = ptr_i.nr - ROW_W'(1);
      adv_o.nc = ptr_i.nc + COL_W'(1);
    end else begin
      adv_o.fd = a_d;
      adv_o.nr = a_r[ROW_W-1:0];
      adv_o.nc = a_c[COL_W-1:0];
    end
  end

  always_comb begin
    r_d   = ptr_i.fd - DIAG_W'(1);
    r_cm1 = cols_i - DIM_W'(1);
    r_r   = (r_d > r_cm1) ? r_d - r_cm1 : '0;
    r_c   = r_d - r_r;
    if ((nr4 + DIM_W'(1)) < rows_i && ptr_i.nc != '0) begin
      ret_o.fd = ptr_i.fd;
      ret_o.nr = ptr_i.nr + ROW_W'(1);
      ret_o.nc = ptr_i.nc - COL_W'(1);
    end else if (ptr_i.fd == '0) begin
      ret_o = '0;
    end else begin
      ret_o.fd = r_d;
      ret_o.nr = r_r[ROW_W-1:0];
      ret_o.nc = r_c[COL_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/young_tableau_priority_queue.sv -----
// Young tableau min priority queue on an 8x8 grid of exchanging cells.
// A refused word gives its result in the cycle after acceptance; an insert or
// extract walks one cell per cycle across the grid until its key has settled.
// One word in flight; the next is taken once the walk has finished.
// Reset (and any register write) empties the store; reset sets an 8 by 8 grid.
`default_nettype none
module young_tableau_priority_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  ytpq_in_if.sink           in_i,
  ytpq_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import ytpq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic [DIM_W-1:0] rows_q, cols_q, dim_new, dim_lim;
  ptr_t             ptr_q, ptr_adv, ptr_ret, ptr_ext;
  logic [CNT_W-1:0] cnt_q, cap;
  logic             state_q, sink_q;
  logic [ST_W-1:0]  res_st_q;
  key_t             res_min_q;
  logic             ov_q;
  logic [ST_W-1:0]  ost_q;
  key_t             omin_q;
  logic [CNT_W-1:0] ocnt_q;

  logic cfg_wr, accept, is_ins, full, empty, ins_ok, ext_ok, any_swap, cnt_gt1;
  logic refused, res_done;
  key_t key_sat, moved;
  cell_cmd_t cmd;

  key_t  val   [MAX_ROWS][MAX_COLS];
  swap_t sw    [MAX_ROWS][MAX_COLS];
  key_t  gated [MAX_ROWS*MAX_COLS];
  logic  swp   [MAX_ROWS*MAX_COLS];

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign prdata  = {28'd0, (paddr[2] == REG_COLS) ? cols_q : rows_q};
  assign dim_lim = (paddr[2] == REG_COLS) ? DIM_W'(MAX_COLS) : DIM_W'(MAX_ROWS);
  assign dim_new = (pwdata == '0) ? DIM_W'(1) :
                   (pwdata > 32'(dim_lim)) ? dim_lim : pwdata[DIM_W-1:0];

  ytpq_ptr u_ptr (
    .ptr_i  (ptr_q),
    .rows_i (rows_q),
    .cols_i (cols_q),
    .adv_o  (ptr_adv),
    .ret_o  (ptr_ret)
  );

  assign cap     = CNT_W'(rows_q) * CNT_W'(cols_q);
  assign accept  = in_i.valid & in_i.ready;
  assign is_ins  = (in_i.op == OP_INSERT);
  assign full    = cnt_q >= cap;
  assign empty   = cnt_q == '0;
  assign ins_ok  = accept & is_ins & ~full;
  assign ext_ok  = accept & ~is_ins & ~empty;
  assign refused = accept & ~ins_ok & ~ext_ok;
  assign res_done = (state_q == S_RUN) & ~any_swap;
  assign cnt_gt1 = cnt_q > CNT_W'(1);
  assign ptr_ext = (cnt_q < cap) ? ptr_ret : ptr_q;
  assign key_sat = (in_i.key == EMPTY_KEY) ? EMPTY_KEY - 32'sd1 : in_i.key;

  assign cmd.clear = cfg_wr;
  assign cmd.start = ins_ok | ext_ok;
  assign cmd.step  = (state_q == S_RUN);
  assign cmd.sink  = sink_q;

  assign in_i.ready = (state_q == S_IDLE) & (~ov_q | out_o.ready);

  for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
    for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
      key_t  up_v, left_v, down_v, right_v, wv;
      swap_t nb;
      logic  m_old, m_ext, is_top, wen, tset;

      assign up_v    = (r > 0) ? val[(r > 0) ? r-1 : 0][c] : EMPTY_KEY;
      assign left_v  = (c > 0) ? val[r][(c > 0) ? c-1 : 0] : EMPTY_KEY;
      assign down_v  = (r < MAX_ROWS-1) ? val[(r < MAX_ROWS-1) ? r+1 : r][c] : EMPTY_KEY;
      assign right_v = (c < MAX_COLS-1) ? val[r][(c < MAX_COLS-1) ? c+1 : c] : EMPTY_KEY;

      assign nb.up    = (r > 0) ? sw[(r > 0) ? r-1 : 0][c].down : 1'b0;
      assign nb.left  = (c > 0) ? sw[r][(c > 0) ? c-1 : 0].right : 1'b0;
      assign nb.down  = (r < MAX_ROWS-1) ? sw[(r < MAX_ROWS-1) ? r+1 : r][c].up : 1'b0;
      assign nb.right = (c < MAX_COLS-1) ? sw[r][(c < MAX_COLS-1) ? c+1 : c].left : 1'b0;

      assign is_top = (r == 0) && (c == 0);
      assign m_old  = (ptr_q.nr == ROW_W'(r)) && (ptr_q.nc == COL_W'(c));
      assign m_ext  = (ptr_ext.nr == ROW_W'(r)) && (ptr_ext.nc == COL_W'(c));

      // extract: last filled cell emptied, its key moved to the top
      assign wen  = is_ins ? m_old : (m_ext | (is_top & cnt_gt1));
      assign wv   = is_ins ? key_sat : ((is_top & cnt_gt1) ? moved : EMPTY_KEY);
      assign tset = is_ins ? m_old : is_top;

      assign gated[r*MAX_COLS+c] = m_ext ? val[r][c] : '0;
      assign swp[r*MAX_COLS+c]   = |sw[r][c];

      ytpq_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .cmd_i      (cmd),
        .has_up_i   (r > 0),
        .has_left_i (c > 0),
        .up_i       (up_v),
        .left_i     (left_v),
        .down_i     (down_v),
        .right_i    (right_v),
        .nb_swap_i  (nb),
        .wr_en_i    (wen),
        .wr_val_i   (wv),
        .tok_set_i  (tset),
        .val_o      (val[r][c]),
        .swap_o     (sw[r][c])
      );
    end
  end

  always_comb begin
    moved    = '0;
    any_swap = 1'b0;
    for (int i = 0; i < MAX_ROWS*MAX_COLS; i++) begin
      moved    = moved | gated[i];
      any_swap = any_swap | swp[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DIM_W'(MAX_ROWS);
      cols_q  <= DIM_W'(MAX_COLS);
      ptr_q   <= '0;
      cnt_q   <= '0;
      state_q <= S_IDLE;
      sink_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      // hold the result word until taken, raise it for a new one
      ov_q <= (~cfg_wr & (refused | res_done)) | (ov_q & ~out_o.ready);
      if (cfg_wr) begin
        if (paddr[2] == REG_COLS) begin
          cols_q <= dim_new;
        end else begin
          rows_q <= dim_new;
        end
        ptr_q <= '0;
        cnt_q <= '0;
      end else if (ins_ok) begin
        cnt_q   <= cnt_q + CNT_W'(1);
        ptr_q   <= ((cnt_q + CNT_W'(1)) < cap) ? ptr_adv : ptr_q;
        state_q <= S_RUN;
        sink_q  <= 1'b0;
      end else if (ext_ok) begin
        cnt_q   <= cnt_q - CNT_W'(1);
        ptr_q   <= ptr_ext;
        state_q <= S_RUN;
        sink_q  <= 1'b1;
      end else if (res_done) begin
        // walk has settled: hand the word out
        state_q <= S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_ok) begin
      res_st_q  <= ST_OK;
      res_min_q <= EMPTY_KEY;
    end else if (ext_ok) begin
      res_st_q  <= ST_OK;
      res_min_q <= val[0][0];
    end
    if (accept && !ins_ok && !ext_ok) begin
      ost_q  <= is_ins ? ST_FULL : ST_EMPTY;
      omin_q <= EMPTY_KEY;
      ocnt_q <= cnt_q;
    end else if (state_q == S_RUN && !any_swap) begin
      ost_q  <= res_st_q;
      omin_q <= res_min_q;
      ocnt_q <= cnt_q;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.status    = ost_q;
  assign out_o.min_value = omin_q;
  assign out_o.count     = ocnt_q;

endmodule
`default_nettype wire
